// ----- rtl/assert_macros.svh -----
// Assertion macros used by the step unit of the calendar stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CDS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("calendar stepper invariant violated");

`define CDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar stepper implication violated");

`define CDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar stepper sequence violated");

`else

`define CDS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define CDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define CDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/cds_pkg.sv -----
// Types, constants and calendar rule functions of the calendar day stepper.
package cds_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int LOAD_SERIAL_W = 24;
    localparam int LEN_W    = 5;
    localparam int R100_W   = 7;
    localparam int R30_W    = 5;
    localparam int Q100_W   = 8;
    localparam int Q30_W    = 10;

    localparam logic [YEAR_W-1:0]  YEAR_TOP  = 14'd9999;
    localparam logic [R100_W-1:0]  R100_TOP  = 7'd99;
    localparam logic [1:0]         C4_TOP    = 2'd3;
    localparam logic [R30_W-1:0]   R30_TOP   = 5'd29;
    localparam logic [R30_W-1:0]   R30_OF_TOP = 5'd10;
    localparam logic [R30_W-1:0]   R30_OF_ZERO = 5'd1;

    // Reciprocal multipliers: floor(x * MUL / 2^QUO_SHIFT) equals floor(x / divisor)
    // for every year value that the 14-bit field can carry.
    localparam logic [12:0] Q100_MUL  = 13'd5243;
    localparam logic [14:0] Q30_MUL   = 15'd17477;
    localparam int          QUO_SHIFT = 19;

    typedef enum logic [1:0] {
        CAL_GREGORIAN = 2'd0,
        CAL_ETHIOPIAN = 2'd1,
        CAL_ISLAMIC   = 2'd2
    } cal_kind_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [WDAY_W-1:0]        wday;
        logic [LOAD_SERIAL_W-1:0] serial;
    } req_t;

    typedef struct packed {
        req_t              req;
        logic [Q100_W-1:0] q100;
        logic [Q30_W-1:0]  q30;
    } req_pre_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  wday;
        logic [R100_W-1:0]  r100;
        logic [1:0]         c4;
        logic [R30_W-1:0]   r30;
    } cal_state_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  wday;
        logic [LEN_W-1:0]   month_length;
        logic               leap;
        logic               wrapped;
    } res_t;

    // The year is described by its low two bits, year mod 100, the century
    // count mod 4, and (year + 1) mod 30.
    function automatic logic is_leap(cal_kind_t kind, logic [1:0] ylo,
                                     logic [R100_W-1:0] r100, logic [1:0] c4,
                                     logic [R30_W-1:0] r30);
        logic lp;
        case (kind)
            CAL_ETHIOPIAN: lp = (ylo == 2'd3);
            CAL_ISLAMIC:
            begin
                case (r30) inside
                    5'd2, 5'd5, 5'd7, 5'd10, 5'd13, 5'd15, 5'd18, 5'd20,
                    5'd24, 5'd26, 5'd29: lp = 1'b1;
                    default: lp = 1'b0;
                endcase
            end
            default:
            begin
                if (r100 == '0)
                    lp = (c4 == 2'd0);
                else
                    lp = (ylo == 2'd0);
            end
        endcase
        return lp;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(cal_kind_t kind,
                                                   logic [MONTH_W-1:0] month,
                                                   logic lp);
        logic [LEN_W-1:0] len;
        case (kind)
            CAL_ETHIOPIAN:
            begin
                if (month == 4'd13)
                    len = lp ? 5'd6 : 5'd5;
                else
                    len = 5'd30;
            end
            CAL_ISLAMIC:
            begin
                if (month == 4'd12)
                    len = lp ? 5'd30 : 5'd29;
                else
                    len = month[0] ? 5'd30 : 5'd29;
            end
            default:
            begin
                case (month) inside
                    4'd2: len = lp ? 5'd29 : 5'd28;
                    4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                    default: len = 5'd31;
                endcase
            end
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/cds_in_stage.sv -----
// Input register of the calendar stepper with year quotient precomputation.
module cds_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cds_pkg::req_t     in_req,
    output logic              pre_valid,
    input  logic              pre_take,
    output cds_pkg::req_pre_t pre_item
);
    import cds_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    req_pre_t          item_reg;
    logic              accept;
    logic [YEAR_W:0]   year_p1;
    logic [26:0]       prod100;
    logic [29:0]       prod30;

    assign in_ready = !valid_reg || pre_take;
    assign accept   = in_valid && in_ready;

    // Quotients by 100 of the year and by 30 of the year plus one, for loads.
    assign year_p1 = {1'b0, in_req.year} + 15'd1;
    assign prod100 = 27'(in_req.year) * 27'(Q100_MUL);
    assign prod30  = 30'(year_p1) * 30'(Q30_MUL);

    assign valid_next = accept || (valid_reg && !pre_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req  <= in_req;
            item_reg.q100 <= prod100[QUO_SHIFT +: Q100_W];
            item_reg.q30  <= prod30[QUO_SHIFT +: Q30_W];
        end
    end

    assign pre_valid = valid_reg;
    assign pre_item  = item_reg;

endmodule

// ----- rtl/cds_step_unit.sv -----
// Date state, one-day step logic and result register of the calendar stepper.
`include "assert_macros.svh"

module cds_step_unit
#(
    parameter int SERIAL_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_wdata,
    input  logic                   pre_valid,
    output logic                   pre_take,
    input  cds_pkg::req_pre_t      pre_item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output cds_pkg::res_t          res,
    output logic [SERIAL_BITS-1:0] res_serial
);
    import cds_pkg::*;

    cal_kind_t              kind_reg;
    cal_state_t             st_reg;
    cal_state_t             st_next;
    logic [SERIAL_BITS-1:0] serial_reg;
    logic [SERIAL_BITS-1:0] serial_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   out_reg;
    res_t                   out_next;
    logic [SERIAL_BITS-1:0] out_serial_reg;

    logic                   lp_cur;
    logic [LEN_W-1:0]       len_cur;
    logic [MONTH_W-1:0]     last_month;
    cal_state_t             yinc;
    cal_state_t             ydec;
    logic                   lp_dec;
    logic                   wrap_next;
    logic                   lp_next;
    logic [YEAR_W-1:0]      load_r100_full;
    logic [YEAR_W:0]        load_yp1;
    logic [YEAR_W:0]        load_r30_full;
    logic [YEAR_W-1:0]      q100_times;
    logic [YEAR_W:0]        q30_times;
    req_t                   req;

    assign req      = pre_item.req;
    assign pre_take = pre_valid && (!out_valid_reg || res_ready);

    // Remainders of a loaded year from the registered quotients.
    assign q100_times     = 14'(pre_item.q100) * 14'd100;
    assign load_r100_full = req.year - q100_times;
    assign load_yp1       = {1'b0, req.year} + 15'd1;
    assign q30_times      = 15'(pre_item.q30) * 15'd30;
    assign load_r30_full  = load_yp1 - q30_times;

    assign lp_cur     = is_leap(kind_reg, st_reg.year[1:0], st_reg.r100, st_reg.c4, st_reg.r30);
    assign len_cur    = month_len(kind_reg, st_reg.month, lp_cur);
    assign last_month = (kind_reg == CAL_ETHIOPIAN) ? 4'd13 : 4'd12;

    // Year one forward, with its residues.
    always_comb
    begin
        yinc = st_reg;
        if (st_reg.year >= YEAR_TOP)
        begin
            yinc.year = '0;
            yinc.r100 = '0;
            yinc.c4   = '0;
            yinc.r30  = R30_OF_ZERO;
        end
        else
        begin
            yinc.year = st_reg.year + 14'd1;
            yinc.r100 = (st_reg.r100 == R100_TOP) ? '0 : st_reg.r100 + 7'd1;
            yinc.c4   = (st_reg.r100 == R100_TOP) ? st_reg.c4 + 2'd1 : st_reg.c4;
            yinc.r30  = (st_reg.r30 == R30_TOP) ? '0 : st_reg.r30 + 5'd1;
        end
    end

    // Year one back, with its residues.
    always_comb
    begin
        ydec = st_reg;
        if (st_reg.year == '0)
        begin
            ydec.year = YEAR_TOP;
            ydec.r100 = R100_TOP;
            ydec.c4   = C4_TOP;
            ydec.r30  = R30_OF_TOP;
        end
        else
        begin
            ydec.year = st_reg.year - 14'd1;
            ydec.r100 = (st_reg.r100 == '0) ? R100_TOP : st_reg.r100 - 7'd1;
            ydec.c4   = (st_reg.r100 == '0) ? st_reg.c4 - 2'd1 : st_reg.c4;
            ydec.r30  = (st_reg.r30 == '0) ? R30_TOP : st_reg.r30 - 5'd1;
        end
    end

    assign lp_dec = is_leap(kind_reg, ydec.year[1:0], ydec.r100, ydec.c4, ydec.r30);

    always_comb
    begin
        st_next     = st_reg;
        serial_next = serial_reg;
        wrap_next   = 1'b0;
        unique case (req.op)
            OP_LOAD:
            begin
                st_next.year  = req.year;
                st_next.month = req.month;
                st_next.day   = req.day;
                st_next.wday  = req.wday;
                st_next.r100  = load_r100_full[R100_W-1:0];
                st_next.c4    = pre_item.q100[1:0];
                st_next.r30   = load_r30_full[R30_W-1:0];
                serial_next   = SERIAL_BITS'(signed'(req.serial));
            end
            OP_NEXT:
            begin
                if (st_reg.day < len_cur)
                    st_next.day = st_reg.day + 5'd1;
                else if (st_reg.month == last_month)
                begin
                    st_next.day   = 5'd1;
                    st_next.month = 4'd1;
                    st_next.year  = yinc.year;
                    st_next.r100  = yinc.r100;
                    st_next.c4    = yinc.c4;
                    st_next.r30   = yinc.r30;
                    wrap_next     = (st_reg.year >= YEAR_TOP);
                end
                else
                begin
                    st_next.day   = 5'd1;
                    st_next.month = st_reg.month + 4'd1;
                end
                st_next.wday = (st_reg.wday >= 3'd6) ? 3'd0 : st_reg.wday + 3'd1;
                serial_next  = serial_reg + SERIAL_BITS'(1);
            end
            OP_PREV:
            begin
                if (st_reg.day > 5'd1)
                    st_next.day = st_reg.day - 5'd1;
                else if (st_reg.month == 4'd1)
                begin
                    st_next.year  = ydec.year;
                    st_next.r100  = ydec.r100;
                    st_next.c4    = ydec.c4;
                    st_next.r30   = ydec.r30;
                    st_next.month = last_month;
                    st_next.day   = month_len(kind_reg, last_month, lp_dec);
                    wrap_next     = (st_reg.year == '0);
                end
                else
                begin
                    st_next.month = st_reg.month - 4'd1;
                    st_next.day   = month_len(kind_reg, st_reg.month - 4'd1, lp_cur);
                end
                st_next.wday = (st_reg.wday == 3'd0 || st_reg.wday > 3'd6) ? 3'd6
                                                                           : st_reg.wday - 3'd1;
                serial_next  = serial_reg - SERIAL_BITS'(1);
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    assign lp_next = is_leap(kind_reg, st_next.year[1:0], st_next.r100, st_next.c4, st_next.r30);

    always_comb
    begin
        out_next.year         = st_next.year;
        out_next.month        = st_next.month;
        out_next.day          = st_next.day;
        out_next.wday         = st_next.wday;
        out_next.month_length = month_len(kind_reg, st_next.month, lp_next);
        out_next.leap         = lp_next;
        out_next.wrapped      = wrap_next;
    end

    assign out_valid_next = pre_take || (out_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= CAL_GREGORIAN;
            st_reg.year   <= '0;
            st_reg.month  <= 4'd1;
            st_reg.day    <= 5'd1;
            st_reg.wday   <= '0;
            st_reg.r100   <= '0;
            st_reg.c4     <= '0;
            st_reg.r30    <= R30_OF_ZERO;
            serial_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                kind_reg <= cal_kind_t'(cfg_wdata);
            if (pre_take)
            begin
                st_reg     <= st_next;
                serial_reg <= serial_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_take)
        begin
            out_reg        <= out_next;
            out_serial_reg <= serial_next;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res        = out_reg;
    assign res_serial = out_serial_reg;

    `CDS_ASSERT_ALWAYS(a_r100_range, clk, rst_n, st_reg.r100 <= R100_TOP)
    `CDS_ASSERT_ALWAYS(a_r30_range, clk, rst_n, st_reg.r30 <= R30_TOP)
    `CDS_ASSERT_NEXT(a_take_fills_out, clk, rst_n, pre_take, out_valid_reg)
    `CDS_ASSERT_IMPL(a_wrap_year, clk, rst_n, out_valid_reg && out_reg.wrapped, out_reg.year == '0 || out_reg.year == YEAR_TOP)

endmodule

// ----- rtl/calendar_day_stepper.sv -----
// Top level of the calendar day stepper: stream ports, input stage and step unit.
//
// Channel   Direction  Content
// s_axis    in         step request: op in tuser, load date and serial in tdata
// m_axis    out        date after the step, month length, leap and wrap flags
// cfg       in         calendar kind register write
//
// One request enters per cycle unless m_tready stalls; a taken request passes the input register
// and then the result register before its result is valid. Each step is combinational from the stored date.
// Reset sets the date to year 0, month 1, day 1, weekday 0, serial 0, Gregorian rules.
// A stalled result register holds one result while the input register holds the next.
module calendar_day_stepper
#(
    parameter int SERIAL_BITS = 24,
    localparam int M_TDATA_W = ((cds_pkg::YEAR_W + cds_pkg::MONTH_W + cds_pkg::DAY_W
                                 + cds_pkg::WDAY_W + SERIAL_BITS + cds_pkg::LEN_W + 2
                                 + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // load_year, load_month, load_day, load_weekday, load_serial
    input  logic [55:0]          s_tdata,
    // op
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // year_now, month_now, day_now, weekday_now, serial_now, month_length,
    // leap_flag, year_wrapped
    output logic [M_TDATA_W-1:0] m_tdata
);
    import cds_pkg::*;

    req_t                   in_req;
    req_pre_t               pre_item;
    logic                   pre_valid;
    logic                   pre_take;
    res_t                   res;
    logic [SERIAL_BITS-1:0] res_serial;

    assign in_req.op     = s_tuser;
    assign in_req.year   = s_tdata[13:0];
    assign in_req.month  = s_tdata[17:14];
    assign in_req.day    = s_tdata[22:18];
    assign in_req.wday   = s_tdata[25:23];
    assign in_req.serial = s_tdata[49:26];

    cds_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .pre_valid (pre_valid),
        .pre_take  (pre_take),
        .pre_item  (pre_item)
    );

    cds_step_unit #(
        .SERIAL_BITS (SERIAL_BITS)
    ) u_step_unit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pre_valid  (pre_valid),
        .pre_take   (pre_take),
        .pre_item   (pre_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res),
        .res_serial (res_serial)
    );

    assign m_tdata = M_TDATA_W'({res.wrapped, res.leap, res.month_length, res_serial,
                                 res.wday, res.day, res.month, res.year});

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the calendar day stepper: request driver, date predictor and result monitor.
module tb_top;
    import cds_pkg::*;

    localparam logic [1:0] CAL_RESERVED = 2'd3;
    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam int SERIAL_W = 24;
    localparam int M_W = 64;
    localparam int YEAR_LAST = 9999;
    localparam int PHASE_COUNT = 8;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [WDAY_W-1:0]   wday;
        logic [SERIAL_W-1:0] serial;
        logic [LEN_W-1:0]    month_length;
        logic                leap;
        logic                wrapped;
    } date_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [1:0]     cfg_wdata = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [55:0]    s_tdata = '0;
    logic [1:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    req_t         pending_reqs[$];
    date_result_t expected_dates[$];
    req_t         req_on_bus;

    logic [1:0]          cal_kind = CAL_GREGORIAN;
    logic [YEAR_W-1:0]   date_year = '0;
    logic [MONTH_W-1:0]  date_month = 4'd1;
    logic [DAY_W-1:0]    date_day = 5'd1;
    logic [WDAY_W-1:0]   date_wday = '0;
    logic [SERIAL_W-1:0] date_serial = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    int greg_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic [1:0] phase_kinds[PHASE_COUNT] = '{CAL_GREGORIAN, CAL_ETHIOPIAN, CAL_ISLAMIC,
                                            CAL_RESERVED, CAL_ISLAMIC, CAL_GREGORIAN,
                                            CAL_ETHIOPIAN, CAL_GREGORIAN};

    calendar_day_stepper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic leap_year(logic [YEAR_W-1:0] y);
        int yi;
        int r;
        yi = y;
        if (cal_kind == CAL_ETHIOPIAN)
            return ((yi + 1) % 4) == 0;
        if (cal_kind == CAL_ISLAMIC)
        begin
            r = (yi + 1) % 30;
            case (r)
                2, 5, 7, 10, 13, 15, 18, 20, 24, 26, 29: return 1'b1;
                default: return 1'b0;
            endcase
        end
        if ((yi % 400) == 0)
            return 1'b1;
        if ((yi % 100) == 0)
            return 1'b0;
        return (yi % 4) == 0;
    endfunction

    function automatic int days_in_month(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
        logic lp;
        lp = leap_year(y);
        if (cal_kind == CAL_ETHIOPIAN)
            return (m == 4'd13) ? (lp ? 6 : 5) : 30;
        if (cal_kind == CAL_ISLAMIC)
        begin
            if (m == 4'd12)
                return lp ? 30 : 29;
            return m[0] ? 30 : 29;
        end
        if (m == 4'd2)
            return lp ? 29 : 28;
        if (m >= 4'd1 && m <= 4'd12)
            return greg_days[m - 1];
        return 31;
    endfunction

    function automatic int last_month();
        return (cal_kind == CAL_ETHIOPIAN) ? 13 : 12;
    endfunction

    function automatic date_result_t step_date(req_t rq);
        date_result_t res;
        logic wrapped;
        int last;
        wrapped = 1'b0;
        last = last_month();
        case (rq.op)
            OP_LOAD:
            begin
                date_year = rq.year;
                date_month = rq.month;
                date_day = rq.day;
                date_wday = rq.wday;
                date_serial = rq.serial;
            end
            OP_NEXT:
            begin
                if (date_day < days_in_month(date_year, date_month))
                    date_day = date_day + 5'd1;
                else if (date_month == last)
                begin
                    date_day = 5'd1;
                    date_month = 4'd1;
                    if (date_year >= YEAR_LAST)
                    begin
                        date_year = '0;
                        wrapped = 1'b1;
                    end
                    else
                        date_year = date_year + 14'd1;
                end
                else
                begin
                    date_day = 5'd1;
                    date_month = date_month + 4'd1;
                end
                date_wday = (date_wday >= 3'd6) ? 3'd0 : date_wday + 3'd1;
                date_serial = date_serial + 24'd1;
            end
            OP_PREV:
            begin
                if (date_day > 5'd1)
                    date_day = date_day - 5'd1;
                else
                begin
                    if (date_month == 4'd1)
                    begin
                        if (date_year == '0)
                        begin
                            date_year = 14'(YEAR_LAST);
                            wrapped = 1'b1;
                        end
                        else
                            date_year = date_year - 14'd1;
                        date_month = 4'(last);
                    end
                    else
                        date_month = date_month - 4'd1;
                    date_day = 5'(days_in_month(date_year, date_month));
                end
                date_wday = (date_wday == 3'd0 || date_wday > 3'd6) ? 3'd6 : date_wday - 3'd1;
                date_serial = date_serial - 24'd1;
            end
            default:
            begin
            end
        endcase
        res.year = date_year;
        res.month = date_month;
        res.day = date_day;
        res.wday = date_wday;
        res.serial = date_serial;
        res.month_length = 5'(days_in_month(date_year, date_month));
        res.leap = leap_year(date_year);
        res.wrapped = wrapped;
        return res;
    endfunction

    function automatic string format_date(date_result_t d);
        return $sformatf("year=%0d month=%0d day=%0d wday=%0d serial=%h len=%0d leap=%0d wrap=%0d",
                         d.year, d.month, d.day, d.wday, d.serial, d.month_length, d.leap,
                         d.wrapped);
    endfunction

    task automatic log_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic queue_request(logic [1:0] op, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                 logic [DAY_W-1:0] d, logic [WDAY_W-1:0] w,
                                 logic [SERIAL_W-1:0] s);
        req_t rq;
        rq.op = op;
        rq.year = y;
        rq.month = m;
        rq.day = d;
        rq.wday = w;
        rq.serial = s;
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_step(logic [1:0] op);
        queue_request(op, '0, '0, '0, '0, '0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                expected_dates.push_back(step_date(req_on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, req_on_bus.serial, req_on_bus.wday, req_on_bus.day,
                                req_on_bus.month, req_on_bus.year};
                    s_tuser <= req_on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        date_result_t seen;
        date_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.year = m_tdata[13:0];
            seen.month = m_tdata[17:14];
            seen.day = m_tdata[22:18];
            seen.wday = m_tdata[25:23];
            seen.serial = m_tdata[49:26];
            seen.month_length = m_tdata[54:50];
            seen.leap = m_tdata[55];
            seen.wrapped = m_tdata[56];
            if (expected_dates.size() == 0)
                log_failure({"unexpected result ", format_date(seen)});
            else
            begin
                want = expected_dates.pop_front();
                if (seen !== want)
                    log_failure({"expected ", format_date(want), " got ", format_date(seen)});
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : main_sequence
        int p;
        int count;
        int run_len;
        int dir;
        int i;
        int sel;
        int len;
        int dd;
        logic [YEAR_W-1:0] y;
        logic [MONTH_W-1:0] m;
        logic [1:0] op;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= phase_kinds[p];
            @(posedge clk);
            cfg_we <= 1'b0;
            cal_kind = phase_kinds[p];
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase

            if (p == 0)
            begin
                // Steps from the reset date wrap the year both ways.
                queue_step(OP_IDLE);
                queue_step(OP_PREV);
                queue_step(OP_NEXT);
                // Leap day of a 400-year, serial wrap upward and weekday 7.
                queue_request(OP_LOAD, 14'd2000, 4'd2, 5'd28, 3'd7, 24'h7FFFFF);
                queue_step(OP_NEXT);
                queue_step(OP_NEXT);
                queue_step(OP_PREV);
                // Century year without a leap day, serial wrap downward.
                queue_request(OP_LOAD, 14'd1900, 4'd3, 5'd1, 3'd0, 24'h800000);
                queue_step(OP_PREV);
                // Year above the last valid year wraps forward to zero.
                queue_request(OP_LOAD, 14'd16383, 4'd12, 5'd31, 3'd6, 24'hFFFFFF);
                queue_step(OP_NEXT);
                // Month zero steps back to month 15 and forward again to zero.
                queue_request(OP_LOAD, 14'd5, 4'd0, 5'd1, 3'd3, 24'h000000);
                queue_step(OP_PREV);
                queue_step(OP_NEXT);
                // Day zero in an out-of-range month.
                queue_request(OP_LOAD, 14'd7, 4'd14, 5'd0, 3'd1, 24'h000001);
                queue_step(OP_PREV);
                // Day beyond the month length ends the month.
                queue_request(OP_LOAD, 14'd2023, 4'd4, 5'd31, 3'd2, 24'h123456);
                queue_step(OP_NEXT);
                queue_request(OP_LOAD, 14'd9999, 4'd1, 5'd1, 3'd5, 24'h000000);
                queue_step(OP_PREV);
                queue_step(OP_IDLE);
                queue_request(OP_LOAD, 14'd16383, 4'd15, 5'd31, 3'd7, 24'hFFFFFF);
                queue_step(OP_PREV);
                queue_step(OP_NEXT);
            end

            // Runs of day steps after loads, most placed near month and year boundaries and some fully random.
            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(99);
                if (sel < 12)
                begin
                    queue_request(OP_LOAD, 14'($urandom_range(16383)), 4'($urandom_range(15)),
                                  5'($urandom_range(31)), 3'($urandom_range(7)),
                                  24'($urandom));
                    count++;
                end
                else if (sel < 85)
                begin
                    sel = $urandom_range(9);
                    if (sel < 3)
                        y = 14'(9990 + $urandom_range(9));
                    else if (sel < 5)
                        y = 14'($urandom_range(10));
                    else
                        y = 14'($urandom_range(YEAR_LAST));
                    sel = $urandom_range(9);
                    if (sel < 5)
                        m = 4'(last_month());
                    else if (sel < 7)
                        m = 4'd1;
                    else
                        m = 4'($urandom_range(last_month(), 1));
                    len = days_in_month(y, m);
                    if ($urandom_range(1) == 1)
                    begin
                        dd = len - int'($urandom_range(3));
                        if (dd < 1)
                            dd = 1;
                    end
                    else
                        dd = $urandom_range(3, 1);
                    queue_request(OP_LOAD, y, m, 5'(dd), 3'($urandom_range(6)), 24'($urandom));
                    count++;
                end
                run_len = $urandom_range(30, 1);
                dir = $urandom_range(4);
                for (i = 0; i < run_len; i++)
                begin
                    if ($urandom_range(99) < 3)
                        queue_step(OP_IDLE);
                    if (dir < 2)
                        op = OP_NEXT;
                    else if (dir < 4)
                        op = OP_PREV;
                    else
                        op = ($urandom_range(1) == 1) ? OP_NEXT : OP_PREV;
                    queue_step(op);
                    count++;
                end
            end

            do
                @(negedge clk);
            while (pending_reqs.size() != 0 || s_tvalid || expected_dates.size() != 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cds_pkg.sv
rtl/cds_in_stage.sv
rtl/cds_step_unit.sv
rtl/calendar_day_stepper.sv
tb/sv/tb_top.sv
